// File: design/mqtt_publish_deframer_macros.svh
// Assertion macros used by the deframer parser module.
`ifndef MQTT_PUBLISH_DEFRAMER_MACROS_SVH
`define MQTT_PUBLISH_DEFRAMER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define MPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define MPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mpd_pkg.sv
// Types and constants shared by the MQTT publish deframer modules.
package mpd_pkg;

    localparam int BYTE_W   = 8;
    localparam int REG_W    = 16;
    localparam int GROUP_W  = 7;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_LENGTH  = 3'd1,
        PH_SKIP    = 3'd2,
        PH_TLEN_HI = 3'd3,
        PH_TLEN_LO = 3'd4,
        PH_TOPIC   = 3'd5,
        PH_PAYLOAD = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_TOPIC   = 2'd1,
        KIND_PAYLOAD = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_LENCODE   = 2'd2,
        ST_OVERSIZE  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CFG_MAX_BODY      = 2'd0,
        CFG_EMIT_TOPIC    = 2'd1,
        CFG_MESSAGE_LIMIT = 2'd2
    } t_cfg_idx;

    // Configuration as seen by the parser.
    typedef struct packed {
        logic [REG_W-1:0] max_body;
        logic             emit_topic;
        logic [REG_W-1:0] message_limit;
    } t_cfg;

    // Byte held in the input register.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } t_item;

    // One result item.
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              eom;
        t_status           status;
        logic              done;
    } t_result;

endpackage

// File: design/mpd_in_stage.sv
// Input register for the received byte stream.
module mpd_in_stage
    import mpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_data,
    input  logic              i_advance,
    output logic              o_ready,
    output t_item             o_item
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_data;

    // Refill whenever empty or the held item moves on this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_item = '{valid: r_valid, data: r_data};

endmodule

// File: design/mpd_parser.sv
// Packet parser state machine: one byte per step, zero or one result.
`include "mqtt_publish_deframer_macros.svh"

module mpd_parser
    import mpd_pkg::*;
#(
    parameter int LENGTH_BYTES_MAX = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam int ACC_W = GROUP_W * LENGTH_BYTES_MAX;

    t_phase            r_phase,     n_phase;
    logic              r_is_pub,    n_is_pub;
    logic [ACC_W-1:0]  r_accum,     n_accum;
    logic [1:0]        r_len_idx,   n_len_idx;
    logic [REG_W-1:0]  r_body_left, n_body_left;
    logic [BYTE_W-1:0] r_tlen_hi,   n_tlen_hi;
    logic [REG_W-1:0]  r_topic_left, n_topic_left;
    logic [REG_W-1:0]  r_msg_count, n_msg_count;
    logic              r_halted,    n_halted;

    logic              active;
    logic [ACC_W-1:0]  group_sh;
    logic [ACC_W-1:0]  accum_sum;
    logic [REG_W-1:0]  body_dec;
    logic [REG_W-1:0]  topic_dec;
    logic [REG_W-1:0]  tlen_full;
    logic              count_msg;
    logic              res_valid;
    t_kind             res_kind;
    logic [BYTE_W-1:0] res_data;
    logic              res_eom;
    t_status           res_status;

    // Done is judged against live config, so lowering the limit takes effect at once.
    assign active = i_step && !r_halted &&
                    !((i_cfg.message_limit != '0) && (r_msg_count >= i_cfg.message_limit));

    assign group_sh  = ACC_W'(i_byte[GROUP_W-1:0]) << (5'(r_len_idx) * 5'(GROUP_W));
    // Groups land in disjoint bit ranges, so OR is the same as add.
    assign accum_sum = r_accum | group_sh;
    assign body_dec  = (r_body_left != '0) ? r_body_left - 1'b1 : r_body_left;
    assign topic_dec = (r_topic_left != '0) ? r_topic_left - 1'b1 : r_topic_left;
    assign tlen_full = {r_tlen_hi, i_byte};

    always_comb begin
        n_phase      = r_phase;
        n_is_pub     = r_is_pub;
        n_accum      = r_accum;
        n_len_idx    = r_len_idx;
        n_body_left  = r_body_left;
        n_tlen_hi    = r_tlen_hi;
        n_topic_left = r_topic_left;
        n_halted     = r_halted;
        count_msg    = 1'b0;
        res_valid    = 1'b0;
        res_kind     = KIND_NONE;
        res_data     = '0;
        res_eom      = 1'b0;
        res_status   = ST_OK;

        if (active) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_is_pub  = (i_byte[7:4] == 4'd3);
                    n_accum   = '0;
                    n_len_idx = '0;
                    n_phase   = PH_LENGTH;
                end
                PH_LENGTH: begin
                    n_accum = accum_sum;
                    if (i_byte[7]) begin
                        if (3'(r_len_idx) + 3'd1 >= 3'(LENGTH_BYTES_MAX)) begin
                            n_halted   = 1'b1;
                            res_valid  = 1'b1;
                            res_status = ST_LENCODE;
                        end else begin
                            n_len_idx = r_len_idx + 2'd1;
                        end
                    end else if (32'(accum_sum) > 32'(i_cfg.max_body)) begin
                        n_halted   = 1'b1;
                        res_valid  = 1'b1;
                        res_status = ST_OVERSIZE;
                    end else begin
                        n_body_left = REG_W'(accum_sum);
                        if (!r_is_pub) begin
                            n_phase = (n_body_left != '0) ? PH_SKIP : PH_HEADER;
                        end else if (n_body_left < REG_W'(2)) begin
                            n_phase    = (n_body_left != '0) ? PH_SKIP : PH_HEADER;
                            res_valid  = 1'b1;
                            res_status = ST_MALFORMED;
                        end else begin
                            n_phase = PH_TLEN_HI;
                        end
                    end
                end
                PH_SKIP: begin
                    n_body_left = body_dec;
                    if (body_dec == '0) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_TLEN_HI: begin
                    n_tlen_hi   = i_byte;
                    n_body_left = r_body_left - 1'b1;
                    n_phase     = PH_TLEN_LO;
                end
                PH_TLEN_LO: begin
                    n_body_left = r_body_left - 1'b1;
                    priority if (tlen_full > n_body_left) begin
                        n_phase    = (n_body_left != '0) ? PH_SKIP : PH_HEADER;
                        res_valid  = 1'b1;
                        res_status = ST_MALFORMED;
                    end else if (tlen_full != '0) begin
                        n_topic_left = tlen_full;
                        n_phase      = PH_TOPIC;
                    end else if (n_body_left != '0) begin
                        n_topic_left = tlen_full;
                        n_phase      = PH_PAYLOAD;
                    end else begin
                        // Empty topic and empty payload: status-only end marker.
                        n_topic_left = tlen_full;
                        n_phase      = PH_HEADER;
                        count_msg    = 1'b1;
                        res_valid    = 1'b1;
                        res_eom      = 1'b1;
                    end
                end
                PH_TOPIC: begin
                    n_body_left  = body_dec;
                    n_topic_left = topic_dec;
                    if (topic_dec == '0) begin
                        n_phase = (body_dec != '0) ? PH_PAYLOAD : PH_HEADER;
                    end
                    count_msg = (topic_dec == '0) && (body_dec == '0);
                    if (i_cfg.emit_topic) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_TOPIC;
                        res_data  = i_byte;
                        res_eom   = count_msg;
                    end else if (count_msg) begin
                        res_valid = 1'b1;
                        res_eom   = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    n_body_left = body_dec;
                    res_valid   = 1'b1;
                    res_kind    = KIND_PAYLOAD;
                    res_data    = i_byte;
                    if (body_dec == '0) begin
                        n_phase   = PH_HEADER;
                        count_msg = 1'b1;
                        res_eom   = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end

        n_msg_count = (count_msg && (r_msg_count != '1)) ? r_msg_count + 1'b1 : r_msg_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_is_pub     <= 1'b0;
            r_accum      <= '0;
            r_len_idx    <= '0;
            r_body_left  <= '0;
            r_tlen_hi    <= '0;
            r_topic_left <= '0;
            r_msg_count  <= '0;
            r_halted     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_is_pub     <= n_is_pub;
            r_accum      <= n_accum;
            r_len_idx    <= n_len_idx;
            r_body_left  <= n_body_left;
            r_tlen_hi    <= n_tlen_hi;
            r_topic_left <= n_topic_left;
            r_msg_count  <= n_msg_count;
            r_halted     <= n_halted;
        end
    end

    assign o_res_valid = res_valid;
    assign o_res = '{
        kind:   res_kind,
        data:   res_data,
        eom:    res_eom,
        status: res_status,
        done:   (i_cfg.message_limit != '0) && (n_msg_count >= i_cfg.message_limit)
    };

    `MPD_ASSERT_NEXT(a_halt_sticky, r_halted, r_halted, "halt cleared without reset")
    `MPD_ASSERT_ALWAYS(a_halt_no_result, !(r_halted && res_valid),
        "result produced while halted")
    `MPD_ASSERT_ALWAYS(a_data_status_ok, !(res_valid && res_kind != KIND_NONE) || res_status == ST_OK,
        "data result with error status")
    `MPD_ASSERT_ALWAYS(a_eom_status_ok, !(res_valid && res_eom) || res_status == ST_OK,
        "end of message on error result")
    `MPD_ASSERT_NEXT(a_count_moves, active && count_msg && r_msg_count != '1,
        r_msg_count == $past(r_msg_count) + 1'b1, "message count did not advance")

endmodule

// File: design/mpd_out_stage.sv
// Result register driving the output stream.
module mpd_out_stage
    import mpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_advance,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Register is free when empty or being drained this cycle.
    assign o_advance = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: design/mqtt_publish_deframer.sv
// A byte accepted into the input register yields its result (if any) via the result register on the output.
// Throughput: one byte per cycle; the input register, parser and result register
// form a two-stage pipeline that moves whenever the result register is free or drained.
// A stalled output holds both stages; no byte is lost.
// Reset (i_rst_n low, synchronous): parser back to header wait, counters and halt cleared,
// both pipeline stages emptied, config to max_body 1536, emit_topic 0, message_limit 0.
module mqtt_publish_deframer
    import mpd_pkg::*;
#(
    parameter int LENGTH_BYTES_MAX = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    // Result stream out
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_out, [9:8] status, [10] done_res
    output logic [1:0]  o_m_axis_tuser,   // [1:0] byte_kind
    output logic        o_m_axis_tlast,   // end_of_message
    // Register write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_item   in_item;
    logic    advance;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    // Config registers: always writable; index 3 is ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_body      <= REG_W'(1536);
            r_cfg.emit_topic    <= 1'b0;
            r_cfg.message_limit <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MAX_BODY:      r_cfg.max_body      <= i_cfg_data;
                CFG_EMIT_TOPIC:    r_cfg.emit_topic    <= i_cfg_data[0];
                CFG_MESSAGE_LIMIT: r_cfg.message_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Stage 1: capture the received byte.
    mpd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_data    (i_s_axis_tdata),
        .i_advance (advance),
        .o_ready   (o_s_axis_tready),
        .o_item    (in_item)
    );

    // The parser state steps exactly once per byte, as it leaves stage 1.
    assign step = in_item.valid && advance;

    mpd_parser #(
        .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (in_item.data),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Stage 2: result register; bytes with no result simply leave it empty.
    mpd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (step && res_valid),
        .i_res       (res),
        .i_ready     (i_m_axis_tready),
        .o_advance   (advance),
        .o_valid     (o_m_axis_tvalid),
        .o_res       (out_res)
    );

    assign o_m_axis_tdata = {5'd0, out_res.done, out_res.status, out_res.data};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.eom;

endmodule
